[rtl/keyframe_table_sampler_top_macros.svh]
// Assertion macros for the keyframe table sampler checker
`ifndef KEYFRAME_TABLE_SAMPLER_TOP_MACROS_SVH
`define KEYFRAME_TABLE_SAMPLER_TOP_MACROS_SVH
`define KTS_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: check failed");
`define KTS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: check failed");
`endif

[rtl/kts_pkg.sv]
// Types and constants shared by the keyframe table sampler
package kts_pkg;
   localparam int unsigned FRAC_BITS = 16;
   localparam logic [1:0] REG_PRESENT  = 2'd0;
   localparam logic [1:0] REG_START    = 2'd1;
   localparam logic [1:0] REG_END      = 2'd2;
   localparam logic [1:0] REG_INTERVAL = 2'd3;
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;
   localparam logic [30:0] INTERVAL_RESET = 31'd65536;

   typedef struct packed {
      logic        op;
      logic [4:0]  key_index;
      logic [2:0]  component;
      logic [31:0] key_value;
      logic [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value_0;
      logic [31:0] value_1;
      logic [31:0] value_2;
      logic [31:0] value_3;
      logic [31:0] value_4;
      logic [31:0] value_5;
      logic [31:0] ratio_to_last;
      logic        ratio_fault;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;
endpackage

[rtl/kts_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle
module kts_divider
   import kts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff[62:0], quo_ff[63]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (div_req.start) begin
         quo_in = div_req.dividend; rem_in = '0; den_in = div_req.divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64] || rem_ff[63]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign div_sts.quotient = quo_ff;
endmodule

[rtl/keyframe_table_sampler_top.sv]
// Keyframe table sampler: key memory, sequencer and shared divider
//  channel | ports                         | handshake
//  request | start, busy, req_payload      | start & !busy
//  result  | rsp_strobe, rsp_payload       | strobe, one cycle, no stall
//  config  | csr_we, csr_index, csr_wdata  | csr_we
// A write item leaves busy low; a sample with no table answers in the next cycle.
// Otherwise busy holds through each run of the 64-step divider (key position, then ratio),
// the blend of each value (two single-port reads, subtract, multiply, add) and the
// sequencing. A zero divisor, or fewer than six values per key, skips the ratio run.
// The strobe follows in the cycle busy drops; the receiver cannot stall.
// Reset clears control and the config registers; the key memory and datapath are not cleared.
module keyframe_table_sampler_top
   import kts_pkg::*;
#(
   parameter int unsigned KEY_COUNT = 20,
   parameter int unsigned VALUES_PER_KEY = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int unsigned DEPTH = KEY_COUNT * VALUES_PER_KEY;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned VW = (VALUES_PER_KEY > 1) ? $clog2(VALUES_PER_KEY) : 1;
   localparam int unsigned KW = $clog2(KEY_COUNT);
   localparam logic [AW-1:0] LAST_BASE = AW'((KEY_COUNT - 1) * VALUES_PER_KEY);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV1, S_POS, S_RDA, S_RDB, S_MUL, S_PROD, S_BLEND, S_RDD, S_GOTD, S_DIV2,
      S_DONE
   } state_type;

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic [AW-1:0] raddr;

   state_type   state_ff;
   logic        present_ff;
   logic [31:0] start_ff, end_ff;
   logic [30:0] ival_ff;
   logic [AW-1:0] base_a_ff, base_b_ff;
   logic [2:0]  comp_ff;
   logic [15:0] frac_ff;
   logic signed [31:0] a_ff;
   logic signed [32:0] diff_ff;
   logic signed [49:0] prod_ff;
   logic [31:0] vals_ff [6];
   logic        neg_ff;
   logic        strobe_ff;
   rsp_type     rsp_ff;
   div_req_type div_req;
   div_sts_type div_sts;

   logic signed [32:0] t_c, st_c, en_c, d_c;
   logic [63:0] pos_hi;
   logic signed [63:0] num_c;
   logic [63:0] q_c;
   logic signed [32:0] blend_c;

   kts_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_sts(div_sts));

   always_comb begin
      st_c = {start_ff[31], start_ff};
      en_c = {end_ff[31], end_ff};
      t_c = {req_payload.sample_time[31], req_payload.sample_time};
      if (t_c < st_c) t_c = st_c;
      else if (t_c > en_c) t_c = en_c;
      d_c = t_c - st_c;
      if (d_c < 0) d_c = '0;
      num_c = {{32{vals_ff[5][31]}}, vals_ff[5]};
      pos_hi = div_sts.quotient >> FRAC_BITS;
      q_c = div_sts.quotient;
      blend_c = $signed({a_ff[31], a_ff}) + 33'(prod_ff >>> FRAC_BITS);
      div_req = '0;
      if (state_ff == S_IDLE && start && req_payload.op == OP_SAMPLE && present_ff) begin
         div_req.start = 1'b1;
         div_req.dividend = 64'(d_c) << FRAC_BITS;
         div_req.divisor = (ival_ff == '0) ? 64'd1 : 64'(ival_ff);
      end else if (state_ff == S_GOTD && VALUES_PER_KEY > 5 && rdata_ff != '0) begin
         div_req.start = 1'b1;
         div_req.dividend = 64'(num_c[63] ? -num_c : num_c) << FRAC_BITS;
         div_req.divisor = 64'(rdata_ff[31] ? -$signed({rdata_ff[31], rdata_ff}) :
                                              $signed({1'b0, rdata_ff}));
      end
      raddr = base_a_ff + AW'(comp_ff);
      if (state_ff == S_RDB) raddr = base_b_ff + AW'(comp_ff);
      if (state_ff == S_RDD) raddr = LAST_BASE + AW'(5);
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (state_ff == S_IDLE && start && req_payload.op == OP_WRITE &&
          32'(req_payload.key_index) < KEY_COUNT && 32'(req_payload.component) < VALUES_PER_KEY)
         mem[AW'(32'(req_payload.key_index) * VALUES_PER_KEY + 32'(req_payload.component))]
            <= req_payload.key_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; strobe_ff <= 1'b0;
         present_ff <= 1'b0; start_ff <= '0; end_ff <= '0; ival_ff <= INTERVAL_RESET;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_PRESENT:  present_ff <= csr_wdata[0];
               REG_START:    start_ff <= csr_wdata;
               REG_END:      end_ff <= csr_wdata;
               REG_INTERVAL: ival_ff <= csr_wdata[30:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (start && req_payload.op == OP_SAMPLE) begin
               if (present_ff) state_ff <= S_DIV1;
               else begin
                  rsp_ff <= '0; strobe_ff <= 1'b1;
               end
            end
            S_DIV1: if (div_sts.done) state_ff <= S_POS;
            S_POS: begin
               // clamp to last key with zero fraction
               if (pos_hi >= 64'(KEY_COUNT - 1)) begin
                  base_a_ff <= LAST_BASE; base_b_ff <= LAST_BASE; frac_ff <= '0;
               end else begin
                  base_a_ff <= AW'(32'(pos_hi[KW-1:0]) * VALUES_PER_KEY);
                  base_b_ff <= AW'((32'(pos_hi[KW-1:0]) + 1) * VALUES_PER_KEY);
                  frac_ff <= q_c[15:0];
               end
               comp_ff <= '0;
               for (int i = 0; i < 6; i++) vals_ff[i] <= '0;
               state_ff <= S_RDA;
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               a_ff <= rdata_ff; state_ff <= S_MUL;
            end
            S_MUL: begin
               diff_ff <= $signed({rdata_ff[31], rdata_ff}) - $signed({a_ff[31], a_ff});
               state_ff <= S_PROD;
            end
            // hold while the product register takes the new difference
            S_PROD: state_ff <= S_BLEND;
            S_BLEND: begin
               vals_ff[comp_ff] <= blend_c[31:0];
               if (32'(comp_ff) + 1 >= VALUES_PER_KEY || comp_ff == 3'd5) state_ff <= S_RDD;
               else begin
                  comp_ff <= comp_ff + 3'd1; state_ff <= S_RDA;
               end
            end
            S_RDD: state_ff <= S_GOTD;
            S_GOTD: begin
               neg_ff <= num_c[63] ^ rdata_ff[31];
               rsp_ff.found <= 1'b1;
               rsp_ff.value_0 <= vals_ff[0]; rsp_ff.value_1 <= vals_ff[1];
               rsp_ff.value_2 <= vals_ff[2]; rsp_ff.value_3 <= vals_ff[3];
               rsp_ff.value_4 <= vals_ff[4]; rsp_ff.value_5 <= vals_ff[5];
               if (VALUES_PER_KEY <= 5 || rdata_ff == '0) begin
                  rsp_ff.ratio_fault <= 1'b1;
                  rsp_ff.ratio_to_last <= num_c > 0 ? 32'h7FFFFFFF :
                                          num_c < 0 ? 32'h80000000 : 32'h0;
                  strobe_ff <= 1'b1; state_ff <= S_IDLE;
               end else state_ff <= S_DIV2;
            end
            S_DIV2: if (div_sts.done) state_ff <= S_DONE;
            S_DONE: begin
               // saturate magnitude against signed range
               rsp_ff.ratio_fault <= 1'b0;
               if (!neg_ff) begin
                  if (q_c > 64'h7FFFFFFF) begin
                     rsp_ff.ratio_to_last <= 32'h7FFFFFFF; rsp_ff.ratio_fault <= 1'b1;
                  end else rsp_ff.ratio_to_last <= q_c[31:0];
               end else begin
                  if (q_c > 64'h80000000) begin
                     rsp_ff.ratio_to_last <= 32'h80000000; rsp_ff.ratio_fault <= 1'b1;
                  end else rsp_ff.ratio_to_last <= 32'(-q_c);
               end
               strobe_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) prod_ff <= diff_ff * $signed({1'b0, frac_ff});

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule

[rtl/kts_checker.sv]
// Port-level checker for the keyframe table sampler, bound to the top level
`include "keyframe_table_sampler_top_macros.svh"
module kts_checker
   import kts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);
   `KTS_ASSERT_NEXT(a_write_no_busy, clock, reset, start && !busy && req_payload.op == OP_WRITE, !busy && !rsp_strobe)
   `KTS_ASSERT_NEXT(a_strobe_cause, clock, reset, !busy && !(start && req_payload.op == OP_SAMPLE), !rsp_strobe)
   `KTS_ASSERT_IMPL(a_not_found_zero, clock, reset, rsp_strobe && !rsp_payload.found, rsp_payload.ratio_fault == 1'b0 && rsp_payload.value_5 == '0)
   `KTS_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_strobe, !busy)
endmodule

bind keyframe_table_sampler_top kts_checker u_kts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
);
